// ----- design/xalu_pkg.sv -----
// Shared opcodes, size codes, pipeline depths, stage types and helpers of the x86-style ALU.
package xalu_pkg;

   localparam logic [3:0] OP_AND  = 4'd0;
   localparam logic [3:0] OP_TEST = 4'd1;
   localparam logic [3:0] OP_OR   = 4'd2;
   localparam logic [3:0] OP_XOR  = 4'd3;
   localparam logic [3:0] OP_NOT  = 4'd4;
   localparam logic [3:0] OP_NEG  = 4'd5;
   localparam logic [3:0] OP_ADD  = 4'd6;
   localparam logic [3:0] OP_SUB  = 4'd7;
   localparam logic [3:0] OP_CMP  = 4'd8;
   localparam logic [3:0] OP_IMUL = 4'd9;
   localparam logic [3:0] OP_IDIV = 4'd10;
   localparam logic [3:0] OP_SHL  = 4'd11;
   localparam logic [3:0] OP_SHR  = 4'd12;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;

   localparam int WORD_W    = 32;
   localparam int DIV_STEPS = 32;
   // abs stage, one stage per quotient bit, sign fix stage
   localparam int DIV_LAT   = DIV_STEPS + 2;

   typedef struct packed {
      logic              valid;
      logic [3:0]        cmd;
      logic [1:0]        size;
      logic [WORD_W-1:0] dst;
      logic [WORD_W-1:0] src;
      logic [WORD_W-1:0] res;
      logic              err;
   } stage_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              cf;
      logic              pf;
      logic              zf;
      logic              sf;
      logic              of;
      logic              wb;
      logic              err;
   } flags_type;

   function automatic logic [WORD_W-1:0] size_mask(input logic [1:0] size);
      case (size)
         SIZE_8:  size_mask = 32'h0000_00FF;
         SIZE_16: size_mask = 32'h0000_FFFF;
         default: size_mask = 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic top_bit(input logic [WORD_W-1:0] v, input logic [1:0] size);
      case (size)
         SIZE_8:  top_bit = v[7];
         SIZE_16: top_bit = v[15];
         default: top_bit = v[31];
      endcase
   endfunction

endpackage

// ----- design/xalu_exec.sv -----
// Non-divide operations of the ALU: logic, add/sub, low product and shifts.
module xalu_exec (
   input  logic [3:0]  cmd,
   input  logic [31:0] dst,
   input  logic [31:0] src,
   output logic [31:0] res,
   output logic        bad_cmd
);

   always_comb begin
      res     = '0;
      bad_cmd = 1'b0;
      case (cmd)
         xalu_pkg::OP_AND, xalu_pkg::OP_TEST: res = dst & src;
         xalu_pkg::OP_OR:   res = dst | src;
         xalu_pkg::OP_XOR:  res = dst ^ src;
         xalu_pkg::OP_NOT:  res = ~dst;
         xalu_pkg::OP_NEG:  res = 32'd0 - dst;
         xalu_pkg::OP_ADD:  res = dst + src;
         xalu_pkg::OP_SUB, xalu_pkg::OP_CMP: res = dst - src;
         xalu_pkg::OP_IMUL: res = dst * src;
         xalu_pkg::OP_IDIV: res = '0;
         xalu_pkg::OP_SHL:  res = dst << src[4:0];
         xalu_pkg::OP_SHR:  res = dst >> src[4:0];
         default:           bad_cmd = 1'b1;
      endcase
   end

endmodule

// ----- design/xalu_div.sv -----
// Pipelined signed divider: one quotient bit per stage, truncating toward zero.
module xalu_div (
   input  logic        clock,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient
);

   localparam int N = xalu_pkg::DIV_STEPS;

   logic [31:0] rem_ff [0:N];
   logic [31:0] quo_ff [0:N];
   logic [31:0] dvs_ff [0:N];
   logic        neg_ff [0:N];
   logic [31:0] rem_in [1:N];
   logic [31:0] quo_in [1:N];
   logic [31:0] q_ff;
   logic [32:0] trial [1:N];
   logic [32:0] diff  [1:N];

   // one restoring step per stage
   always_comb begin
      for (int k = 1; k <= N; k++) begin
         trial[k]  = {rem_ff[k-1], quo_ff[k-1][31]};
         diff[k]   = trial[k] - {1'b0, dvs_ff[k-1]};
         if (!diff[k][32]) begin
            rem_in[k] = diff[k][31:0];
            quo_in[k] = {quo_ff[k-1][30:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][31:0];
            quo_in[k] = {quo_ff[k-1][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      quo_ff[0] <= dividend[31] ? 32'd0 - dividend : dividend;
      dvs_ff[0] <= divisor[31] ? 32'd0 - divisor : divisor;
      neg_ff[0] <= dividend[31] ^ divisor[31];
      for (int k = 1; k <= N; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         dvs_ff[k] <= dvs_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
      q_ff <= neg_ff[N] ? 32'd0 - quo_ff[N] : quo_ff[N];
   end

   assign quotient = q_ff;

endmodule

// ----- design/xalu_flags.sv -----
// Final stage: pick the divide result, mask to size and build the status flags.
module xalu_flags (
   input  xalu_pkg::stage_type meta,
   input  logic [31:0]         quotient,
   output xalu_pkg::flags_type flags
);

   logic [31:0] mask;
   logic [31:0] r;
   logic        arith;
   logic        sd;
   logic        ss;
   logic        div_zero;

   always_comb begin
      mask     = xalu_pkg::size_mask(meta.size);
      r        = ((meta.cmd == xalu_pkg::OP_IDIV) ? quotient : meta.res) & mask;
      div_zero = (meta.cmd == xalu_pkg::OP_IDIV) && (meta.src == '0);
      arith    = (meta.cmd == xalu_pkg::OP_NEG) || (meta.cmd == xalu_pkg::OP_ADD) ||
                 (meta.cmd == xalu_pkg::OP_SUB) || (meta.cmd == xalu_pkg::OP_CMP) ||
                 (meta.cmd == xalu_pkg::OP_IMUL) || (meta.cmd == xalu_pkg::OP_IDIV);
      sd       = xalu_pkg::top_bit(meta.dst, meta.size);
      ss       = xalu_pkg::top_bit(meta.src, meta.size);
      if (((meta.cmd == xalu_pkg::OP_SUB) || (meta.cmd == xalu_pkg::OP_CMP)) &&
          (meta.src != '0)) begin
         ss = ~ss;
      end

      flags        = '0;
      flags.result = r;
      case (meta.cmd)
         xalu_pkg::OP_ADD:                    flags.cf = (r < meta.dst) || (r < meta.src);
         xalu_pkg::OP_SUB, xalu_pkg::OP_CMP:  flags.cf = r > meta.dst;
         xalu_pkg::OP_NEG:                    flags.cf = r != '0;
         default:                             flags.cf = 1'b0;
      endcase
      flags.pf = ~(^r[7:0]);
      flags.zf = r == '0;
      if (arith) begin
         flags.sf = xalu_pkg::top_bit(r, meta.size);
         if (meta.cmd == xalu_pkg::OP_NEG) begin
            flags.of = (meta.dst != '0) && (meta.dst == ((mask >> 1) + 32'd1));
         end else begin
            flags.of = (sd == ss) && (sd != flags.sf);
         end
      end
      flags.wb = (meta.cmd != xalu_pkg::OP_CMP) && (meta.cmd != xalu_pkg::OP_TEST);
      if (meta.err || div_zero) begin
         flags     = '0;
         flags.err = 1'b1;
      end
   end

endmodule

// ----- design/x86_style_alu_with_flags_top.sv -----
// Top level of the pipelined x86-style integer ALU with status flags.
//
// Fully pipelined: busy never rises, so a word may be started on every clock and one result
// word comes out per cycle. Every operation, cheap or not, passes through the same registers
// from the accepting edge to its rsp_valid strobe: the input register, a delay line as deep
// as the divider, which spends one stage on operand magnitudes, one stage per quotient bit
// (32) and one stage on the quotient sign, and the flag stage. Results leave in issue order
// and are shown for exactly one cycle; the receiver must take them then. An unknown command
// or a divide by zero returns error high with every other field zero.
module x86_style_alu_with_flags_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [31:0] req_dest_value,
   input  logic [31:0] req_source_value,
   input  logic [1:0]  req_operand_size,
   output logic        rsp_valid,
   output logic [31:0] rsp_alu_result,
   output logic        rsp_carry_flag,
   output logic        rsp_parity_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_write_back,
   output logic        rsp_error
);

   localparam int DLY = xalu_pkg::DIV_LAT;

   // input register stage
   logic        a_valid_ff;
   logic [3:0]  a_cmd_ff;
   logic [1:0]  a_size_ff;
   logic [31:0] a_dst_ff;
   logic [31:0] a_src_ff;

   logic [31:0]          exec_res;
   logic                 exec_bad;
   xalu_pkg::stage_type  b_in;
   xalu_pkg::stage_type  dly_ff [0:DLY-1];
   logic [31:0]          quotient;
   xalu_pkg::flags_type  flags;
   logic                 out_valid_ff;
   xalu_pkg::flags_type  out_ff;

   // never stall: every stage advances every cycle
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
      end
      a_cmd_ff  <= req_command;
      a_size_ff <= req_operand_size;
      // drop destination bits above the operand size
      a_dst_ff  <= req_dest_value & xalu_pkg::size_mask(req_operand_size);
      a_src_ff  <= req_source_value;
   end

   xalu_exec u_exec (
      .cmd     (a_cmd_ff),
      .dst     (a_dst_ff),
      .src     (a_src_ff),
      .res     (exec_res),
      .bad_cmd (exec_bad)
   );

   xalu_div u_div (
      .clock    (clock),
      .dividend (a_dst_ff),
      .divisor  (a_src_ff),
      .quotient (quotient)
   );

   always_comb begin
      b_in.valid = a_valid_ff;
      b_in.cmd   = a_cmd_ff;
      b_in.size  = a_size_ff;
      b_in.dst   = a_dst_ff;
      b_in.src   = a_src_ff;
      b_in.res   = exec_res;
      b_in.err   = exec_bad;
   end

   // hold operands and early results alongside the divider pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) begin
            dly_ff[k] <= '0;
         end
      end else begin
         dly_ff[0] <= b_in;
         for (int k = 1; k < DLY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   xalu_flags u_flags (
      .meta     (dly_ff[DLY-1]),
      .quotient (quotient),
      .flags    (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dly_ff[DLY-1].valid;
      end
      out_ff <= flags;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_alu_result    = out_ff.result;
   assign rsp_carry_flag    = out_ff.cf;
   assign rsp_parity_flag   = out_ff.pf;
   assign rsp_zero_flag     = out_ff.zf;
   assign rsp_sign_flag     = out_ff.sf;
   assign rsp_overflow_flag = out_ff.of;
   assign rsp_write_back    = out_ff.wb;
   assign rsp_error         = out_ff.err;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##36 rsp_valid)
      else $error("result strobe missing at fixed latency");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_alu_result == '0 && !rsp_write_back && !rsp_carry_flag)
      else $error("error word carries nonzero fields");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_zero_flag == (rsp_alu_result == '0))
      else $error("zero flag disagrees with result");
`endif

endmodule

// ----- bench/x86_style_alu_with_flags_checker.sv -----
// Checker for the x86-style ALU: predicts each result word and compares it with the output.
module x86_style_alu_with_flags_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_command,
   input  logic [31:0] req_dest_value,
   input  logic [31:0] req_source_value,
   input  logic [1:0]  req_operand_size,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_alu_result,
   input  logic        rsp_carry_flag,
   input  logic        rsp_parity_flag,
   input  logic        rsp_zero_flag,
   input  logic        rsp_sign_flag,
   input  logic        rsp_overflow_flag,
   input  logic        rsp_write_back,
   input  logic        rsp_error,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   xalu_pkg::flags_type pending_words[$];

   function automatic xalu_pkg::flags_type alu_predict(input logic [3:0] cmd,
                                                       input logic [31:0] dv,
                                                       input logic [31:0] sv,
                                                       input logic [1:0] sz);
      xalu_pkg::flags_type f;
      logic [31:0] mask, d, r, ma, mb, q;
      logic [63:0] prod;
      logic sd, ss, arith, bad;
      mask = (sz == xalu_pkg::SIZE_8) ? 32'hFF :
             (sz == xalu_pkg::SIZE_16) ? 32'hFFFF : 32'hFFFF_FFFF;
      d = dv & mask;
      sd = (sz == xalu_pkg::SIZE_8) ? d[7] : (sz == xalu_pkg::SIZE_16) ? d[15] : d[31];
      ss = (sz == xalu_pkg::SIZE_8) ? sv[7] : (sz == xalu_pkg::SIZE_16) ? sv[15] : sv[31];
      r = '0; arith = 1'b0; bad = 1'b0; f = '0;
      case (cmd)
         xalu_pkg::OP_AND, xalu_pkg::OP_TEST: r = d & sv;
         xalu_pkg::OP_OR:   r = d | sv;
         xalu_pkg::OP_XOR:  r = d ^ sv;
         xalu_pkg::OP_NOT:  r = ~d;
         xalu_pkg::OP_NEG:  begin r = -d; arith = 1'b1; end
         xalu_pkg::OP_ADD:  begin r = d + sv; arith = 1'b1; end
         xalu_pkg::OP_SUB, xalu_pkg::OP_CMP: begin
            r = d - sv;
            if (sv != 0) ss = ~ss;
            arith = 1'b1;
         end
         xalu_pkg::OP_IMUL: begin prod = d * sv; r = prod[31:0]; arith = 1'b1; end
         xalu_pkg::OP_IDIV: begin
            arith = 1'b1;
            if (sv == 0) bad = 1'b1;
            else begin
               ma = d[31] ? -d : d;
               mb = sv[31] ? -sv : sv;
               q = ma / mb;
               r = (d[31] ^ sv[31]) ? -q : q;
            end
         end
         xalu_pkg::OP_SHL:  r = d << sv[4:0];
         xalu_pkg::OP_SHR:  r = d >> sv[4:0];
         default: bad = 1'b1;
      endcase
      if (bad) begin
         f.err = 1'b1;
         return f;
      end
      r &= mask;
      f.result = r;
      if (cmd == xalu_pkg::OP_ADD) f.cf = (r < d) || (r < sv);
      else if (cmd == xalu_pkg::OP_SUB || cmd == xalu_pkg::OP_CMP) f.cf = r > d;
      else if (cmd == xalu_pkg::OP_NEG) f.cf = r != 0;
      f.pf = ~^r[7:0];
      f.zf = r == 0;
      if (arith) begin
         f.sf = (sz == xalu_pkg::SIZE_8) ? r[7] : (sz == xalu_pkg::SIZE_16) ? r[15] : r[31];
         if (cmd == xalu_pkg::OP_NEG) f.of = (d != 0) && (d == (mask >> 1) + 1);
         else f.of = (sd == ss) && (sd != f.sf);
      end
      f.wb = !(cmd == xalu_pkg::OP_CMP || cmd == xalu_pkg::OP_TEST);
      return f;
   endfunction

   assign pending_count = pending_words.size();

   always @(posedge clock) begin
      xalu_pkg::flags_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_alu_result, rsp_carry_flag, rsp_parity_flag, rsp_zero_flag,
                    rsp_sign_flag, rsp_overflow_flag, rsp_write_back, rsp_error};
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_words.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected res=%h cf%b pf%b zf%b sf%b of%b wb%b err%b",
                           $time, want.result, want.cf, want.pf, want.zf, want.sf, want.of,
                           want.wb, want.err);
                  $display("%0t:          actual   res=%h cf%b pf%b zf%b sf%b of%b wb%b err%b",
                           $time, got.result, got.cf, got.pf, got.zf, got.sf, got.of,
                           got.wb, got.err);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            pending_words.insert(pending_words.size(),
                                 alu_predict(req_command, req_dest_value,
                                             req_source_value, req_operand_size));
      end
   end
endmodule

// ----- bench/x86_style_alu_with_flags_top_tb.sv -----
// Testbench top: drives command words into the ALU and gives the verdict.
module x86_style_alu_with_flags_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1030;

   logic        clock, reset, start, busy;
   logic [3:0]  req_command;
   logic [31:0] req_dest_value, req_source_value;
   logic [1:0]  req_operand_size;
   logic        rsp_valid, rsp_carry_flag, rsp_parity_flag, rsp_zero_flag;
   logic        rsp_sign_flag, rsp_overflow_flag, rsp_write_back, rsp_error;
   logic [31:0] rsp_alu_result;
   int          fail_count, pending_count, idle_cycles;

   x86_style_alu_with_flags_top u_top (.*);
   x86_style_alu_with_flags_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: count cycles with no word moving on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Present one word at the falling edge and hold it until it is accepted.
   task automatic send_word(input logic [3:0] cmd, input logic [31:0] dv,
                            input logic [31:0] sv, input logic [1:0] sz);
      start <= 1'b1;
      req_command <= cmd;
      req_dest_value <= dv;
      req_source_value <= sv;
      req_operand_size <= sz;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start for a number of cycles.
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 >> ($urandom_range(0, 2) * 8);
         3: return $urandom_range(0, 3) - 1;
         4: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int burst;
      logic [3:0] cmd;
      logic [31:0] sv;
      reset = 1'b1;
      start = 1'b0;
      req_command = xalu_pkg::OP_AND;
      req_dest_value = '0;
      req_source_value = '0;
      req_operand_size = xalu_pkg::SIZE_8;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed: every operation, size extremes, divide corner cases, bad opcodes.
      send_word(xalu_pkg::OP_AND,  32'hFFFF_FFFF, 32'hFFFF_FFFF, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_TEST, 32'h0000_00F0, 32'h0F, xalu_pkg::SIZE_8);
      send_word(xalu_pkg::OP_OR,   32'h0, 32'h0, xalu_pkg::SIZE_16);
      send_word(xalu_pkg::OP_XOR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 2'd3);
      send_word(xalu_pkg::OP_NOT,  32'h1234_5678, 32'h0, xalu_pkg::SIZE_16);
      send_word(xalu_pkg::OP_NEG,  32'h80, 32'h0, xalu_pkg::SIZE_8);
      send_word(xalu_pkg::OP_NEG,  32'h8000_0000, 32'h0, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_NEG,  32'h0, 32'h0, xalu_pkg::SIZE_16);
      send_word(xalu_pkg::OP_ADD,  32'hFFFF_FFFF, 32'h1, xalu_pkg::SIZE_8);
      send_word(xalu_pkg::OP_ADD,  32'h7FFF, 32'h1, xalu_pkg::SIZE_16);
      send_word(xalu_pkg::OP_SUB,  32'h0, 32'h1, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_CMP,  32'h8000_0000, 32'h1, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_IMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_IMUL, 32'h1234, 32'h5678, xalu_pkg::SIZE_16);
      send_word(xalu_pkg::OP_IDIV, 32'hFFFF_FFF9, 32'h2, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_IDIV, 32'h8000_0000, 32'hFFFF_FFFF, xalu_pkg::SIZE_32);
      send_word(xalu_pkg::OP_IDIV, 32'h55, 32'h0, xalu_pkg::SIZE_8);
      send_word(xalu_pkg::OP_SHL,  32'hFF, 32'h21, xalu_pkg::SIZE_8);
      send_word(xalu_pkg::OP_SHR,  32'hFFFF_FFFF, 32'h1F, xalu_pkg::SIZE_32);
      send_word(4'd13,   32'h1, 32'h1, xalu_pkg::SIZE_8);
      send_word(4'd15,   32'hFFFF_FFFF, 32'hFFFF_FFFF, xalu_pkg::SIZE_32);

      // Pause until every expected word is back.
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      // Random bursts with random gaps; mostly legal opcodes.
      for (int n = 0; n < RANDOM_WORDS; n += burst) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
            sv = pick_value();
            if (cmd == xalu_pkg::OP_IDIV && sv == 0 && $urandom_range(0, 3) != 0) sv = 32'h3;
            send_word(cmd, pick_value(), sv, 2'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 50));
      end
      start <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
